FILE: hw/rtl/stng_pkg.sv
// Package for the stereo tilt noise generator.
// Holds the sequencer state type, register map, reset values and the xorshift step.
// No dependencies.
`default_nettype none

package stng_pkg;

  // Default sample width (signed fixed point, full scale +-1)
  localparam int unsigned SampleBits = 24;

  // Register map: byte address bit 2 selects the word, byte offset is ignored
  localparam logic RegColour = 1'b0;
  localparam logic RegCoef   = 1'b1;

  localparam logic [16:0] ColourReset = 17'd32768;
  localparam logic [15:0] CoefReset   = 16'd10923;
  localparam logic [31:0] NoiseReset  = 32'd1;

  // Input commands
  localparam logic CmdSample = 1'b0;
  localparam logic CmdLoad   = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT_MUL,
    ST_FILT_UPD,
    ST_TILT_MUL,
    ST_TILT_UPD,
    ST_DONE
  } seq_state_e;

  // One xorshift32 step (shifts 13, 17, 5)
  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] r;
    r = s ^ (s << 13);
    r = r ^ (r >> 17);
    r = r ^ (r << 5);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stereo_tilt_noise_generator.sv
// Stereo tilt noise generator top level: sequencer, shared multiplier, APB registers.
// Depends on stng_pkg.
`default_nettype none

// Stereo colored-noise source. A sample command (cmd_i = 0) draws two xorshift32
// values (left first), runs each through its own one-pole low-pass and mixes white,
// low-passed and high-passed noise per the colour register; one stereo result follows.
// A sample command is accepted, then runs four passes of the single shared
// multiplier (filter then tilt, left then right), each followed by a
// round/add/saturate step, then the output load. The input stalls
// during that work. A load command (cmd_i = 1) reloads the generator from seed_i,
// clears both filters in the accept cycle and gives no result. A result waiting on
// the output does not block the next transfer in. colour at byte 0, filter_coef at
// byte 4; write configuration only while idle.
module stereo_tilt_noise_generator #(
  parameter int unsigned SAMPLE_BITS = stng_pkg::SampleBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [31:0]                   seed_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      left_sample_o,
  output logic signed [SAMPLE_BITS-1:0]      right_sample_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned PW = SB + 19;   // 18-bit signed factor times SB+1 difference
  localparam int unsigned AW = SB + 3;    // rounded product and sums
  localparam logic signed [PW-1:0] RoundHalf = PW'(32768);
  localparam logic signed [AW-1:0] SatMax = AW'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [AW-1:0] SatMin = -SatMax - AW'(1);

  // Saturate a widened sum to the sample range
  function automatic logic signed [SB-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SatMax) begin
      r = SatMax[SB-1:0];
    end else if (v < SatMin) begin
      r = SatMin[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  // Registers
  stng_pkg::seq_state_e state_q, state_d;
  logic [16:0]              colour_q;
  logic [15:0]              coef_q;
  logic [31:0]              noise_q;
  logic signed [SB-1:0]     lp_l_q, lp_r_q;
  logic signed [SB-1:0]     x_l_q, x_r_q;
  logic signed [SB-1:0]     y_l_q, y_r_q;
  logic signed [PW-1:0]     prod_q;
  logic                     ch_q;
  logic                     out_valid_q;
  logic signed [SB-1:0]     out_l_q, out_r_q;

  // Handshakes
  logic in_xfer, cfg_wr, out_free;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_q || !out_stall_i;

  // Draws for the next sample
  logic [31:0] draw_l, draw_r;
  assign draw_l = stng_pkg::xorshift32(noise_q);
  assign draw_r = stng_pkg::xorshift32(draw_l);

  // Tilt factors: dark_sel picks which one of dark and bright is used
  logic        dark_sel;
  logic [16:0] dark_val, bright_val;
  assign dark_sel   = !colour_q[16] && !colour_q[15];
  assign dark_val   = 17'd65536 - {1'b0, colour_q[14:0], 1'b0};
  assign bright_val = colour_q[16] ? 17'd65536 : {1'b0, colour_q[14:0], 1'b0};

  // Current channel operands
  logic signed [SB-1:0] x_cur, lp_cur;
  assign x_cur  = ch_q ? x_r_q : x_l_q;
  assign lp_cur = ch_q ? lp_r_q : lp_l_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stng_pkg::ST_IDLE: begin
        if (in_xfer && (cmd_i == stng_pkg::CmdSample)) state_d = stng_pkg::ST_FILT_MUL;
      end
      stng_pkg::ST_FILT_MUL: state_d = stng_pkg::ST_FILT_UPD;
      stng_pkg::ST_FILT_UPD: state_d = stng_pkg::ST_TILT_MUL;
      stng_pkg::ST_TILT_MUL: state_d = stng_pkg::ST_TILT_UPD;
      stng_pkg::ST_TILT_UPD: state_d = ch_q ? stng_pkg::ST_DONE : stng_pkg::ST_FILT_MUL;
      stng_pkg::ST_DONE: begin
        if (out_free) state_d = stng_pkg::ST_IDLE;
      end
      default: state_d = stng_pkg::ST_IDLE;
    endcase
  end

  // Datapath selects: shared multiplier and shared adder
  logic [16:0]          mul_a;
  logic signed [SB:0]   mul_b;
  logic signed [AW-1:0] add_a, add_b;
  always_comb begin
    in_stall_o = (state_q != stng_pkg::ST_IDLE);
    if (state_q == stng_pkg::ST_TILT_MUL) begin
      mul_a = dark_sel ? dark_val : bright_val;
      mul_b = dark_sel ? ((SB+1)'(lp_cur) - (SB+1)'(x_cur)) : (SB+1)'(lp_cur);
    end else begin
      mul_a = {1'b0, coef_q};
      mul_b = (SB+1)'(x_cur) - (SB+1)'(lp_cur);
    end
    add_a = (state_q == stng_pkg::ST_FILT_UPD) ? AW'(lp_cur) : AW'(x_cur);
    add_b = '0;
  end

  // Product, rounding half up, and the update sum
  logic signed [PW-1:0] prod_d, rsum;
  logic signed [AW-1:0] rnd, upd_sum;
  logic signed [SB-1:0] upd_val;
  assign prod_d  = $signed({1'b0, mul_a}) * mul_b;
  assign rsum    = prod_q + RoundHalf;
  assign rnd     = rsum[PW-1:16];
  assign upd_sum = ((state_q == stng_pkg::ST_TILT_UPD) && !dark_sel)
                   ? add_a + add_b - rnd : add_a + add_b + rnd;
  assign upd_val = sat(upd_sum);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= stng_pkg::ColourReset;
      coef_q   <= stng_pkg::CoefReset;
    end else if (cfg_wr) begin
      if (paddr[2] == stng_pkg::RegColour) colour_q <= pwdata[16:0];
      else                                 coef_q   <= pwdata[15:0];
    end
  end

  // Read back; byte offset bits do not take part in the decode
  always_comb begin
    pready = 1'b1;
    prdata = (paddr[2] == stng_pkg::RegColour) ? {15'd0, colour_q} : {16'd0, coef_q};
  end

  // Sequencer and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stng_pkg::ST_IDLE;
      noise_q <= stng_pkg::NoiseReset;
      lp_l_q  <= '0;
      lp_r_q  <= '0;
      ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        stng_pkg::ST_IDLE: begin
          ch_q <= 1'b0;
          if (in_xfer) begin
            if (cmd_i == stng_pkg::CmdLoad) begin
              noise_q <= seed_i;
              lp_l_q  <= '0;
              lp_r_q  <= '0;
            end else begin
              noise_q <= draw_r;
            end
          end
        end
        stng_pkg::ST_FILT_UPD: begin
          if (ch_q) lp_r_q <= upd_val;
          else      lp_l_q <= upd_val;
        end
        stng_pkg::ST_TILT_UPD: ch_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == stng_pkg::ST_IDLE) begin
      x_l_q <= $signed(draw_l[31 -: SB]);
      x_r_q <= $signed(draw_r[31 -: SB]);
    end
    if (state_q inside {stng_pkg::ST_FILT_MUL, stng_pkg::ST_TILT_MUL}) begin
      prod_q <= prod_d;
    end
    if (state_q == stng_pkg::ST_TILT_UPD) begin
      if (ch_q) y_r_q <= upd_val;
      else      y_l_q <= upd_val;
    end
    if ((state_q == stng_pkg::ST_DONE) && out_free) begin
      out_l_q <= y_l_q;
      out_r_q <= y_r_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == stng_pkg::ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = out_l_q;
  assign right_sample_o = out_r_q;

`ifndef SYNTHESIS
  // A sample transfer keeps the input stalled while the sequencer works
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (cmd_i == stng_pkg::CmdSample) |=> in_stall_o)
    else $error("sample transfer did not start the sequencer");

  // A load transfer reseeds and clears both filters at once
  a_load_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (cmd_i == stng_pkg::CmdLoad) |=>
      (lp_l_q == '0) && (lp_r_q == '0) && (noise_q == $past(seed_i)) && !in_stall_o)
    else $error("load transfer did not reseed and clear filters");

  // Finishing a sample always presents a result
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stng_pkg::ST_DONE) && out_free |=> out_valid_o)
    else $error("finished sample not presented");

  // Right channel is only worked on after left
  a_chan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stng_pkg::ST_FILT_MUL) && ch_q |-> $past(state_q == stng_pkg::ST_TILT_UPD))
    else $error("right channel started out of order");
`endif

endmodule

`default_nettype wire
